// File: hw/rtl/bcu_pkg.sv
// Package for the barometric compensation unit: beat structs, calibration
// struct, register indexes and the shared arithmetic helpers.
// Depends on nothing.
package bcu_pkg;

  // stages of each pipelined divider (one quotient bit per stage)
  localparam int DIV_N = 32;

  // register indexes on the configuration port
  localparam logic [1:0] REG_CAL_A = 2'd0;
  localparam logic [1:0] REG_CAL_B = 2'd1;
  localparam logic [1:0] REG_CAL_C = 2'd2;
  localparam logic [1:0] REG_OSS   = 2'd3;

  typedef struct packed {
    logic [15:0] raw_temp;
    logic [23:0] raw_pressure;
  } in_beat_t;

  typedef struct packed {
    logic signed [11:0] temperature_tenths;
    logic [16:0]        pressure_pa;
    logic               fault;
  } out_beat_t;

  typedef struct packed {
    logic [15:0] ac1;
    logic [15:0] ac2;
    logic [15:0] ac3;
    logic [15:0] ac4;
    logic [15:0] ac5;
    logic [15:0] ac6;
    logic [15:0] b1;
    logic [15:0] b2;
    logic [15:0] mc;
    logic [15:0] md;
    logic [1:0]  oss;
  } cal_t;

  // data that rides along with a sample between the two halves
  typedef struct packed {
    logic [23:0]        up;
    logic signed [11:0] temp;
    logic               flt;
  } side_t;

  function automatic logic [31:0] sx16(logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  // arithmetic right shift on a 32-bit two's complement word
  function automatic logic [31:0] asr(logic [31:0] x, int unsigned n);
    return $unsigned($signed(x) >>> n);
  endfunction

endpackage

// File: hw/rtl/barometric_compensation_unit.sv
// Barometric compensation unit, top level.
// Input beats carry a raw temperature word and a raw 24-bit pressure reading;
// each gives one output beat with temperature in 0.1 C, pressure in Pa and a
// fault flag set when a divisor of the compensation is zero.
// Calibration words and the oversampling mode are written over the APB-style
// port (64-bit data, byte address 8*index); the user must write them only
// while no sample is in flight; the block does not enforce it. It is built of
// two 32-stage pipelined dividers (one quotient bit per stage) and 12 stages
// of shifts, adds and 32x32 multiplies. One beat is taken every cycle while
// in_stall is low. The whole pipeline advances together; it holds when the
// output register is full and out_stall is high, and in_stall is raised in
// that same cycle, so nothing is lost or repeated.
// Reset clears all valid bits, sets the calibration words to zero and the
// oversampling mode to 3.
// Depends on bcu_pkg, bcu_temp, bcu_press, bcu_div.
module barometric_compensation_unit import bcu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  in_beat_t    in_data,
  output logic        out_valid,
  input  logic        out_stall,
  output out_beat_t   out_data,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  // configuration registers
  logic [63:0] cal_a_r, cal_b_r;
  logic [31:0] cal_c_r;
  logic [1:0]  oss_r;
  logic [1:0]  reg_idx;
  logic        wr_en;

  assign reg_idx = paddr[4:3];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cal_a_r <= '0;
      cal_b_r <= '0;
      cal_c_r <= '0;
      oss_r   <= 2'd3;
    end else if (wr_en) begin
      case (reg_idx)
        REG_CAL_A: cal_a_r <= pwdata;
        REG_CAL_B: cal_b_r <= pwdata;
        REG_CAL_C: cal_c_r <= pwdata[31:0];
        REG_OSS:   oss_r   <= pwdata[1:0];
        default:   cal_a_r <= cal_a_r;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_CAL_A: prdata = cal_a_r;
      REG_CAL_B: prdata = cal_b_r;
      REG_CAL_C: prdata = {32'b0, cal_c_r};
      REG_OSS:   prdata = {62'b0, oss_r};
      default:   prdata = '0;
    endcase
  end

  cal_t cal;
  always_comb begin
    cal.ac1 = cal_a_r[63:48];
    cal.ac2 = cal_a_r[47:32];
    cal.ac3 = cal_a_r[31:16];
    cal.ac4 = cal_a_r[15:0];
    cal.ac5 = cal_b_r[63:48];
    cal.ac6 = cal_b_r[47:32];
    cal.b1  = cal_b_r[31:16];
    cal.b2  = cal_b_r[15:0];
    cal.mc  = cal_c_r[31:16];
    cal.md  = cal_c_r[15:0];
    cal.oss = oss_r;
  end

  // global advance: hold only when the output beat is waiting and stalled
  logic        adv;
  logic        t_vld;
  logic [31:0] t_b5;
  side_t       t_side;

  assign adv      = ~(out_valid & out_stall);
  assign in_stall = ~adv;

  bcu_temp u_temp (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (adv),
    .cal     (cal),
    .in_vld  (in_valid),
    .in_beat (in_data),
    .out_vld (t_vld),
    .b5      (t_b5),
    .side    (t_side)
  );

  bcu_press u_press (
    .clk      (clk),
    .rst_n    (rst_n),
    .en       (adv),
    .cal      (cal),
    .in_vld   (t_vld),
    .b5       (t_b5),
    .side     (t_side),
    .out_vld  (out_valid),
    .out_beat (out_data)
  );

endmodule

// File: hw/rtl/bcu_div.sv
// Pipelined 32-bit unsigned restoring divider, one quotient bit per stage.
// Depends on bcu_pkg (DIV_N).
module bcu_div import bcu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  logic        in_vld,
  input  logic [31:0] num,
  input  logic [31:0] den,
  output logic        out_vld,
  output logic [31:0] quo
);

  logic        vld_r [DIV_N];
  logic [31:0] rem_r [DIV_N];
  logic [31:0] num_r [DIV_N];
  logic [31:0] den_r [DIV_N];
  logic [31:0] quo_r [DIV_N];

  for (genvar k = 0; k < DIV_N; k++) begin : g_stage
    logic        v_in;
    logic [31:0] rem_in, num_in, den_in, quo_in;
    logic [32:0] sh;
    logic        ge;
    logic [31:0] rem_nxt;

    if (k == 0) begin : g_first
      assign v_in   = in_vld;
      assign rem_in = '0;
      assign num_in = num;
      assign den_in = den;
      assign quo_in = '0;
    end else begin : g_next
      assign v_in   = vld_r[k-1];
      assign rem_in = rem_r[k-1];
      assign num_in = num_r[k-1];
      assign den_in = den_r[k-1];
      assign quo_in = quo_r[k-1];
    end

    // shift in the next dividend bit, subtract when it fits
    always_comb begin
      sh      = {rem_in, num_in[31]};
      ge      = (sh >= {1'b0, den_in});
      rem_nxt = ge ? 32'(sh - {1'b0, den_in}) : sh[31:0];
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= v_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= {num_in[30:0], 1'b0};
        den_r[k] <= den_in;
        quo_r[k] <= {quo_in[30:0], ge};
      end
    end
  end

  assign out_vld = vld_r[DIV_N-1];
  assign quo     = quo_r[DIV_N-1];

endmodule

// File: hw/rtl/bcu_temp.sv
// Temperature half: X1, the signed X2 division, B5 and the temperature output.
// Depends on bcu_pkg and bcu_div.
module bcu_temp import bcu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  cal_t        cal,
  input  logic        in_vld,
  input  in_beat_t    in_beat,
  output logic        out_vld,
  output logic [31:0] b5,
  output side_t       side
);

  typedef struct packed {
    side_t       s;
    logic [31:0] x1;
    logic        neg;
  } tside_t;

  // stage A: oversampling shift and (UT - ac6) * ac5
  logic        va_r;
  logic [31:0] prod_a_r, prod_a_nxt;
  logic [23:0] up_a_r, up_a_nxt;
  logic [3:0]  shamt;

  always_comb begin
    shamt      = 4'd8 - {2'b00, cal.oss};
    up_a_nxt   = in_beat.raw_pressure >> shamt;
    prod_a_nxt = 32'(({16'b0, in_beat.raw_temp} - {16'b0, cal.ac6}) * {16'b0, cal.ac5});
  end

  // stage B: X1 truncated toward zero, divisor and dividend
  logic        vb_r;
  logic [31:0] x1_b_r, x1_b_nxt, num_b_r, num_b_nxt, den_b_r, den_b_nxt;
  logic [23:0] up_b_r;
  logic [31:0] biased;

  always_comb begin
    biased    = prod_a_r[31] ? 32'(prod_a_r + 32'd32767) : prod_a_r;
    x1_b_nxt  = asr(biased, 15);
    den_b_nxt = 32'(x1_b_nxt + sx16(cal.md));
    num_b_nxt = {{5{cal.mc[15]}}, cal.mc, 11'b0};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
    end else if (en) begin
      va_r <= in_vld;
      vb_r <= va_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a_r <= prod_a_nxt;
      up_a_r   <= up_a_nxt;
      x1_b_r   <= x1_b_nxt;
      num_b_r  <= num_b_nxt;
      den_b_r  <= den_b_nxt;
      up_b_r   <= up_a_r;
    end
  end

  // magnitudes into the divider, signs ride alongside
  logic        den_zero;
  logic [31:0] num_mag, den_mag, quo_mag;
  logic        div_vld;
  tside_t      ts_in;
  tside_t      dl_r [DIV_N];

  always_comb begin
    den_zero = (den_b_r == 32'd0);
    num_mag  = num_b_r[31] ? 32'(-num_b_r) : num_b_r;
    if (den_zero) begin
      den_mag = 32'd1;
    end else begin
      den_mag = den_b_r[31] ? 32'(-den_b_r) : den_b_r;
    end
    ts_in.s.up   = up_b_r;
    ts_in.s.temp = '0;
    ts_in.s.flt  = den_zero;
    ts_in.x1     = x1_b_r;
    ts_in.neg    = num_b_r[31] ^ den_b_r[31];
  end

  bcu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (vb_r),
    .num     (num_mag),
    .den     (den_mag),
    .out_vld (div_vld),
    .quo     (quo_mag)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= ts_in;
      for (int k = 1; k < DIV_N; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  // stage C: B5 and the saturated temperature
  logic        vc_r;
  logic [31:0] b5_c_r, b5_c_nxt, tq, q_s;
  side_t       side_c_r, side_c_nxt;
  tside_t      td;

  always_comb begin
    td         = dl_r[DIV_N-1];
    q_s        = td.neg ? 32'(-quo_mag) : quo_mag;
    b5_c_nxt   = 32'(td.x1 + q_s);
    tq         = asr(32'(b5_c_nxt + 32'd8), 4);
    side_c_nxt = td.s;
    if (td.s.flt) begin
      side_c_nxt.temp = '0;
    end else if ($signed(tq) < -32'sd2048) begin
      side_c_nxt.temp = -12'sd2048;
    end else if ($signed(tq) > 32'sd2047) begin
      side_c_nxt.temp = 12'sd2047;
    end else begin
      side_c_nxt.temp = tq[11:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vc_r <= 1'b0;
    end else if (en) begin
      vc_r <= div_vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      b5_c_r   <= b5_c_nxt;
      side_c_r <= side_c_nxt;
    end
  end

  assign out_vld = vc_r;
  assign b5      = b5_c_r;
  assign side    = side_c_r;

endmodule

// File: hw/rtl/bcu_press.sv
// Pressure half: B6..B7, the unsigned B7/B4 division and the final correction.
// Depends on bcu_pkg and bcu_div. Its last stage is the output register.
module bcu_press import bcu_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        en,
  input  cal_t        cal,
  input  logic        in_vld,
  input  logic [31:0] b5,
  input  side_t       side,
  output logic        out_vld,
  output out_beat_t   out_beat
);

  logic        v1_r, v2_r, v3_r, v4_r, v5_r;
  side_t       s1_r, s2_r, s3_r, s4_r, s5_r;
  logic [31:0] b6_r, sqp_r, a2_r, a3_r, a2_3_r, a3_3_r, mb1_r, mb2_r;
  logic [31:0] b3_r, x3b_r, b4_r, b7_r;
  logic [31:0] sq, x3, t3, b3_nxt, c3, b4_nxt, b7_nxt;

  // stage P3 to P5 combinational pieces
  always_comb begin
    sq     = asr(sqp_r, 12);
    x3     = 32'(asr(mb2_r, 11) + asr(a2_3_r, 11));
    t3     = 32'((32'({{14{cal.ac1[15]}}, cal.ac1, 2'b00} + x3) << cal.oss) + 32'd2);
    b3_nxt = t3[31] ? asr(32'(t3 + 32'd3), 2) : {2'b00, t3[31:2]};
    c3     = 32'(asr(a3_3_r, 13) + asr(mb1_r, 16) + 32'd2);
    b4_nxt = 32'({16'b0, cal.ac4} * 32'(x3b_r + 32'd32768)) >> 15;
    b7_nxt = 32'(32'({8'b0, s4_r.up} - b3_r) * (32'd50000 >> cal.oss));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
      v5_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_vld;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
      v5_r <= v4_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      // P1: B6
      b6_r   <= 32'(b5 - 32'd4000);
      s1_r   <= side;
      // P2: products of B6
      sqp_r  <= 32'(b6_r * b6_r);
      a2_r   <= 32'(sx16(cal.ac2) * b6_r);
      a3_r   <= 32'(sx16(cal.ac3) * b6_r);
      s2_r   <= s1_r;
      // P3: products of the squared term
      mb2_r  <= 32'(sx16(cal.b2) * sq);
      mb1_r  <= 32'(sx16(cal.b1) * sq);
      a2_3_r <= a2_r;
      a3_3_r <= a3_r;
      s3_r   <= s2_r;
      // P4: B3 and the B4 term
      b3_r   <= b3_nxt;
      x3b_r  <= asr(c3, 2);
      s4_r   <= s3_r;
      // P5: B4 and B7
      b4_r   <= b4_nxt;
      b7_r   <= b7_nxt;
      s5_r   <= s4_r;
    end
  end

  // divider feed: B7*2/B4 when B7 is small, else B7/B4 doubled afterward
  typedef struct packed {
    side_t s;
    logic  dbl;
    logic  pflt;
  } pside_t;

  logic        div_vld;
  logic [31:0] div_num, div_den, quo;
  pside_t      ps_in, pd;
  pside_t      dl_r [DIV_N];

  always_comb begin
    ps_in.s    = s5_r;
    ps_in.dbl  = b7_r[31];
    ps_in.pflt = (b4_r == 32'd0);
    div_num    = b7_r[31] ? b7_r : {b7_r[30:0], 1'b0};
    div_den    = (b4_r == 32'd0) ? 32'd1 : b4_r;
  end

  bcu_div u_div (
    .clk     (clk),
    .rst_n   (rst_n),
    .en      (en),
    .in_vld  (v5_r),
    .num     (div_num),
    .den     (div_den),
    .out_vld (div_vld),
    .quo     (quo)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      dl_r[0] <= ps_in;
      for (int k = 1; k < DIV_N; k++) begin
        dl_r[k] <= dl_r[k-1];
      end
    end
  end

  // P7..P10: raw pressure, correction products, sum and saturation
  logic        v7_r, v8_r, v9_r, v10_r;
  pside_t      s7_r, s8_r, s9_r;
  logic [31:0] p7_r, p8_r, p9_r, pp_r, m7_r, x1u_r, x2u_r, p8s, pf;
  out_beat_t   ob_r, ob_nxt;

  always_comb begin
    pd     = dl_r[DIV_N-1];
    p8s    = asr(p7_r, 8);
    pf     = 32'(p9_r + asr(32'(x1u_r + x2u_r + 32'd3791), 4));
    ob_nxt.temperature_tenths = s9_r.s.temp;
    ob_nxt.fault              = s9_r.s.flt | s9_r.pflt;
    if (s9_r.s.flt || s9_r.pflt || pf[31]) begin
      ob_nxt.pressure_pa = '0;
    end else if (pf > 32'd131071) begin
      ob_nxt.pressure_pa = '1;
    end else begin
      ob_nxt.pressure_pa = pf[16:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v7_r  <= 1'b0;
      v8_r  <= 1'b0;
      v9_r  <= 1'b0;
      v10_r <= 1'b0;
    end else if (en) begin
      v7_r  <= div_vld;
      v8_r  <= v7_r;
      v9_r  <= v8_r;
      v10_r <= v9_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      p7_r  <= pd.dbl ? {quo[30:0], 1'b0} : quo;
      s7_r  <= pd;
      pp_r  <= 32'(p8s * p8s);
      m7_r  <= 32'(32'd7357 * p7_r);
      p8_r  <= p7_r;
      s8_r  <= s7_r;
      x1u_r <= asr(32'(pp_r * 32'd3038), 16);
      x2u_r <= asr(32'(32'd0 - m7_r), 16);
      p9_r  <= p8_r;
      s9_r  <= s8_r;
      ob_r  <= ob_nxt;
    end
  end

  assign out_vld  = v10_r;
  assign out_beat = ob_r;

endmodule

// File: hw/rtl/bcu_checker.sv
// Port-level checks for the barometric compensation unit, bound to the top.
// Depends on bcu_pkg.
module bcu_checker import bcu_pkg::*; (
  input logic      clk,
  input logic      rst_n,
  input logic      in_stall,
  input logic      out_valid,
  input logic      out_stall,
  input out_beat_t out_data
);

  // a stalled output beat stays presented
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("output beat dropped while stalled");

  // input stalls only when a finished beat is held back
  a_stall_src: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled without output backpressure");

  // reset empties the pipeline
  a_reset_empty: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("output valid right after reset");

  // a fault beat never reports a pressure
  a_fault_press: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.fault |-> out_data.pressure_pa == 17'd0)
    else $error("pressure nonzero on fault beat");

endmodule

bind barometric_compensation_unit bcu_checker u_bcu_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

// File: verif/barometric_compensation_unit_tb.sv
// Testbench for barometric_compensation_unit: drives raw sample beats, predicts
// each compensated temperature/pressure beat and checks it field by field.
// Depends on bcu_pkg and the unit's RTL.
module barometric_compensation_unit_tb;
  import bcu_pkg::*;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_stall;
  in_beat_t    in_data;
  logic        out_valid;
  logic        out_stall;
  out_beat_t   out_data;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [4:0]  paddr;
  logic [63:0] pwdata;
  logic [63:0] prdata;
  logic        pready;

  barometric_compensation_unit dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  localparam int LATENCY   = 76;
  localparam int MAX_CYCLE = 400000;

  // shadow of the calibration registers
  logic [63:0] cal_a_q, cal_b_q;
  logic [31:0] cal_c_q;
  logic [1:0]  oss_q;

  in_beat_t  sample_q[$];
  out_beat_t comp_expect_q[$];

  int send_idle_pct, recv_stall_pct;
  bit hold_off;
  int hold_cnt;
  int errors, mism;
  longint cycle;

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic logic [31:0] shr_a(logic [31:0] x, int n);
    logic [31:0] r;
    r = x >> n;
    if (x[31]) r = ~((~x) >> n);
    return r;
  endfunction

  // compensation of one raw sample pair with the current calibration
  function automatic out_beat_t compensate(in_beat_t s);
    out_beat_t r;
    logic [31:0] ac1, ac2, ac3, ac4, ac5, ac6, b1, b2, ut, up;
    logic [31:0] b5u, b6, sq, x1u, x2u, x3u, b3, b4, b7, p, prod;
    longint x1, den, b5, t, mc, md;
    int pf;
    ac1 = {{16{cal_a_q[63]}}, cal_a_q[63:48]};
    ac2 = {{16{cal_a_q[47]}}, cal_a_q[47:32]};
    ac3 = {{16{cal_a_q[31]}}, cal_a_q[31:16]};
    ac4 = {16'd0, cal_a_q[15:0]};
    ac5 = {16'd0, cal_b_q[63:48]};
    ac6 = {16'd0, cal_b_q[47:32]};
    b1  = {{16{cal_b_q[31]}}, cal_b_q[31:16]};
    b2  = {{16{cal_b_q[15]}}, cal_b_q[15:0]};
    mc  = longint'($signed(cal_c_q[31:16]));
    md  = longint'($signed(cal_c_q[15:0]));
    ut  = {16'd0, s.raw_temp};
    up  = {8'd0, s.raw_pressure} >> (8 - oss_q);
    r = '0;
    prod = (ut - ac6) * ac5;
    x1 = longint'($signed(prod)) / 32768;
    den = x1 + md;
    if (den == 0) begin
      r.fault = 1'b1;
      return r;
    end
    b5 = x1 + (mc * 2048) / den;
    b5u = b5[31:0];
    t = longint'($signed(shr_a(b5u + 32'd8, 4)));
    if (t < -2048) t = -2048;
    if (t > 2047) t = 2047;
    r.temperature_tenths = t[11:0];
    b6 = b5u - 32'd4000;
    sq = shr_a(b6 * b6, 12);
    x1u = shr_a(b2 * sq, 11);
    x2u = shr_a(ac2 * b6, 11);
    x3u = x1u + x2u;
    b3 = ((ac1 * 32'd4 + x3u) << oss_q) + 32'd2;
    b3 = $signed(b3) / 4;
    x1u = shr_a(ac3 * b6, 13);
    x2u = shr_a(b1 * sq, 16);
    x3u = shr_a(x1u + x2u + 32'd2, 2);
    b4 = (ac4 * (x3u + 32'd32768)) >> 15;
    b7 = (up - b3) * (32'd50000 >> oss_q);
    if (b4 == 0) begin
      r.fault = 1'b1;
      return r;
    end
    if (b7 < 32'h80000000) p = (b7 * 32'd2) / b4;
    else p = (b7 / b4) * 32'd2;
    x1u = shr_a(p, 8) * shr_a(p, 8);
    x1u = shr_a(x1u * 32'd3038, 16);
    x2u = shr_a(32'd0 - 32'd7357 * p, 16);
    p = p + shr_a(x1u + x2u + 32'd3791, 4);
    pf = $signed(p);
    if (pf < 0) pf = 0;
    if (pf > 131071) pf = 131071;
    r.pressure_pa = pf[16:0];
    return r;
  endfunction

  // driver: one beat per acceptance, payload held while stalled
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        comp_expect_q.push_back(compensate(in_data));
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          in_valid <= 1'b1;
          in_data  <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver stall: random, or a long hold-off
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      hold_cnt  <= 0;
    end else if (hold_off && hold_cnt < 300) begin
      out_stall <= 1'b1;
      hold_cnt  <= hold_cnt + 1;
    end else begin
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // monitor: compare against oldest prediction
  always @(posedge clk) begin
    out_beat_t e;
    cycle <= cycle + 1;
    if (rst_n && out_valid && !out_stall) begin
      if (comp_expect_q.size() == 0) begin
        errors <= errors + 1;
        if (mism < 10) $display("unexpected beat: %h", out_data);
        mism <= mism + 1;
      end else begin
        e = comp_expect_q.pop_front();
        if (e !== out_data) begin
          errors <= errors + 1;
          if (mism < 10)
            $display("mismatch: exp t=%0d p=%0d f=%0b got t=%0d p=%0d f=%0b",
              e.temperature_tenths, e.pressure_pa, e.fault,
              out_data.temperature_tenths, out_data.pressure_pa, out_data.fault);
          mism <= mism + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (cycle > MAX_CYCLE) begin
      $display("Verification failed");
      $finish;
    end
  end

  task automatic reg_write(logic [1:0] idx, logic [63:0] val);
    @(posedge clk);
    psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
    paddr <= {idx, 3'b000}; pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
    case (idx)
      REG_CAL_A: cal_a_q = val;
      REG_CAL_B: cal_b_q = val;
      REG_CAL_C: cal_c_q = val[31:0];
      default:   oss_q = val[1:0];
    endcase
  endtask

  task automatic drain();
    while (sample_q.size() > 0 || in_valid || comp_expect_q.size() > 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  // typical calibration, jittered in low bits
  task automatic cal_typical();
    reg_write(REG_CAL_A, {16'd408 ^ 16'($urandom_range(63)), 16'hFFB9, 16'hC46E,
                          16'd32741 ^ 16'($urandom_range(255))});
    reg_write(REG_CAL_B, {16'd32757, 16'd23153 ^ 16'($urandom_range(255)),
                          16'd6190, 16'd4});
    reg_write(REG_CAL_C, {16'h8000 ^ 16'($urandom_range(255)), 16'd2868});
  endtask

  function automatic in_beat_t rnd_sample(bit realistic);
    in_beat_t s;
    if (realistic) begin
      s.raw_temp = 16'($urandom_range(30000, 32000));
      s.raw_pressure = 24'($urandom_range(20000, 60000)) << $urandom_range(5, 8);
    end else begin
      s.raw_temp = 16'($urandom);
      s.raw_pressure = 24'($urandom);
    end
    return s;
  endfunction

  initial begin
    in_beat_t s;
    rst_n = 1'b0; in_valid = 1'b0; in_data = '0; out_stall = 1'b0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    cal_a_q = '0; cal_b_q = '0; cal_c_q = '0; oss_q = 2'd3;
    send_idle_pct = 0; recv_stall_pct = 0; hold_off = 1'b0;
    errors = 0; mism = 0; cycle = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;

    // reset calibration: temperature divisor zero
    s.raw_temp = 16'd0; s.raw_pressure = 24'd0; sample_q.push_back(s);
    s.raw_temp = 16'hFFFF; s.raw_pressure = 24'hFFFFFF; sample_q.push_back(s);
    drain();

    // pressure divisor zero: ac4 = 0, md nonzero
    reg_write(REG_CAL_C, {16'h8000, 16'd2868});
    s.raw_temp = 16'd27898; s.raw_pressure = 24'd23843 << 8; sample_q.push_back(s);
    drain();
    // extremes of calibration words A and B (all ones), all oss
    reg_write(REG_CAL_A, 64'hFFFF_FFFF_FFFF_FFFF);
    reg_write(REG_CAL_B, 64'hFFFF_FFFF_FFFF_FFFF);
    for (int m = 0; m < 4; m++) begin
      reg_write(REG_OSS, 64'(m));
      s.raw_temp = 16'hFFFF; s.raw_pressure = 24'hFFFFFF; sample_q.push_back(s);
      s.raw_temp = 16'h0000; s.raw_pressure = 24'h000000; sample_q.push_back(s);
      s.raw_temp = 16'h8000; s.raw_pressure = 24'h800000; sample_q.push_back(s);
      drain();
    end
    // typical values incl. saturation both ways
    reg_write(REG_OSS, 64'd0);
    cal_typical();
    s.raw_temp = 16'd27898; s.raw_pressure = 24'd23843 << 8; sample_q.push_back(s);
    s.raw_temp = 16'hFFFF; s.raw_pressure = 24'h000000; sample_q.push_back(s);
    s.raw_temp = 16'h0000; s.raw_pressure = 24'hFFFFFF; sample_q.push_back(s);
    drain();

    // random phases with different idle mixes and calibrations
    for (int ph = 0; ph < 8; ph++) begin
      case (ph % 4)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 60; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 60; end
        default: begin send_idle_pct = 18; recv_stall_pct = 18; end
      endcase
      reg_write(REG_OSS, 64'($urandom_range(3)));
      if (ph % 3 == 2) begin
        reg_write(REG_CAL_A, {$urandom, $urandom});
        reg_write(REG_CAL_B, {$urandom, $urandom});
        reg_write(REG_CAL_C, 64'($urandom));
      end else begin
        cal_typical();
      end
      if (ph == 4) hold_off = 1'b1;
      for (int i = 0; i < 125; i++)
        sample_q.push_back(rnd_sample($urandom_range(99) < 75));
      drain();
    end

    if (errors == 0 && comp_expect_q.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

// File: files.f
hw/rtl/bcu_pkg.sv
hw/rtl/bcu_div.sv
hw/rtl/bcu_temp.sv
hw/rtl/bcu_press.sv
hw/rtl/barometric_compensation_unit.sv
hw/rtl/bcu_checker.sv
verif/barometric_compensation_unit_tb.sv
